>>> design/ccc_pkg.sv
// Package for the clock calendar with countdown timer.
// Holds the command codes, the beat layouts and the calendar helper functions.
// No dependencies.
package ccc_pkg;

    // Command carried in the input tuser.
    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_LOAD_CAL = 2'd1,
        MODE_LOAD_CD  = 2'd2,
        MODE_STOP_CD  = 2'd3
    } mode_t;

    localparam int MODE_W     = 2;
    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 64;

    // Range limits.
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [13:0] YEAR_RESET = 14'd2000;
    localparam logic [3:0]  MONTH_MAX  = 4'd12;
    localparam logic [4:0]  HOUR_MAX   = 5'd23;
    localparam logic [6:0]  CD_HOUR_MAX = 7'd99;
    localparam logic [5:0]  MIN_SEC_MAX = 6'd59;

    // Reciprocal of 25 scaled by 2**24, exact for every 14-bit year.
    localparam int          RECIP_SHIFT = 24;
    localparam logic [19:0] RECIP_25    = 20'd671089;

    // Input tdata, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]  pad;
        logic [5:0]  load_second;
        logic [5:0]  load_minute;
        logic [6:0]  load_hour;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [13:0] load_year;
        logic        countdown_view;
        logic        hold_calendar;
    } in_beat_t;

    // Output tdata, last field in the lowest bits.
    typedef struct packed {
        logic [2:0]  pad;
        logic        finished;
        logic        running;
        logic [5:0]  cd_seconds;
        logic [5:0]  cd_minutes;
        logic [6:0]  cd_hours;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } out_beat_t;

    // Gregorian leap test. Divisibility by 25 comes from a constant
    // reciprocal multiply; by 4 and 16 from the low bits.
    function automatic logic is_leap(input logic [13:0] y);
        logic [33:0] prod;
        logic [9:0]  quot;
        logic [14:0] back;
        logic        div25;
        prod  = {20'd0, y} * {14'd0, RECIP_25};
        quot  = prod[33:RECIP_SHIFT];
        back  = ({5'd0, quot} << 4) + ({5'd0, quot} << 3) + {5'd0, quot};
        div25 = (back == {1'b0, y});
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    // Number of days in month m of year y.
    function automatic logic [4:0] month_days(input logic [13:0] y, input logic [3:0] m);
        logic [4:0] days;
        if (m == 4'd2) begin
            days = is_leap(y) ? 5'd29 : 5'd28;
        end else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
            days = 5'd30;
        end else begin
            days = 5'd31;
        end
        return days;
    endfunction

endpackage

>>> design/clock_calendar_countdown_top.sv
// Top level of the clock calendar with countdown timer.
// Depends on ccc_pkg for command codes, beat layouts and calendar functions.
//
// The block takes one command beat per clock cycle while m_tready is high
// and returns exactly one result beat for each, in order. A beat passes an
// input register, then one pass of update logic writes the calendar and
// countdown registers and the result register together; the sustained rate
// is one beat per cycle while m_tready is high, and the result register and
// input register let a new beat in while a result waits. The longest path
// is the leap-year test: a 14 by 20 bit constant multiply for divisibility
// by 25, followed by the day-of-month compare. After reset the calendar
// reads 2000-01-01 00:00:00 and the countdown is stopped at zero.
module clock_calendar_countdown_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Fields from bit 0: hold_calendar, countdown_view, load_year, load_month,
    // load_day, load_hour, load_minute, load_second, zero padding.
    input  logic [ccc_pkg::IN_TDATA_W-1:0]    s_tdata,
    // Fields from bit 0: mode.
    input  logic [ccc_pkg::MODE_W-1:0]        s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: year, month, day, hour, minute, second, cd_hours,
    // cd_minutes, cd_seconds, running, finished, zero padding.
    output logic [ccc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready
);
    import ccc_pkg::*;

    // Input register.
    logic     in_valid_reg;
    mode_t    in_mode_reg;
    in_beat_t in_beat_reg;

    // Calendar and countdown state.
    logic [13:0] cal_year_reg,   cal_year_next;
    logic [3:0]  cal_month_reg,  cal_month_next;
    logic [4:0]  cal_day_reg,    cal_day_next;
    logic [4:0]  cal_hour_reg,   cal_hour_next;
    logic [5:0]  cal_minute_reg, cal_minute_next;
    logic [5:0]  cal_second_reg, cal_second_next;
    logic [6:0]  cnt_hours_reg,   cnt_hours_next;
    logic [5:0]  cnt_minutes_reg, cnt_minutes_next;
    logic [5:0]  cnt_seconds_reg, cnt_seconds_next;
    logic        cnt_running_reg, cnt_running_next;
    logic        finished_next;

    // Result register.
    logic      m_tvalid_reg;
    out_beat_t out_beat_reg, out_beat_next;

    logic advance;

    // Clamped load values and the shared month length.
    logic [13:0] ld_year;
    logic [3:0]  ld_month;
    logic [4:0]  ld_day_raw;
    logic [13:0] year_sel;
    logic [3:0]  month_sel;
    logic [4:0]  md;

    // Handshake: the update pass fires when the input register is full and
    // the result register is free or being emptied.
    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_beat_reg;

    // Input register capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_mode_reg <= mode_t'(s_tuser);
            in_beat_reg <= in_beat_t'(s_tdata);
        end
    end

    // Clamp the calendar load fields and pick the year and month whose
    // length matters for this beat.
    always_comb begin
        ld_year    = (in_beat_reg.load_year > YEAR_MAX) ? YEAR_MAX : in_beat_reg.load_year;
        ld_month   = (in_beat_reg.load_month > MONTH_MAX) ? MONTH_MAX
                   : (in_beat_reg.load_month == 4'd0) ? 4'd1 : in_beat_reg.load_month;
        ld_day_raw = (in_beat_reg.load_day == 5'd0) ? 5'd1 : in_beat_reg.load_day;
        year_sel   = (in_mode_reg == MODE_LOAD_CAL) ? ld_year : cal_year_reg;
        month_sel  = (in_mode_reg == MODE_LOAD_CAL) ? ld_month : cal_month_reg;
        md         = month_days(year_sel, month_sel);
    end

    // One update pass for the beat in the input register.
    always_comb begin
        cal_year_next    = cal_year_reg;
        cal_month_next   = cal_month_reg;
        cal_day_next     = cal_day_reg;
        cal_hour_next    = cal_hour_reg;
        cal_minute_next  = cal_minute_reg;
        cal_second_next  = cal_second_reg;
        cnt_hours_next   = cnt_hours_reg;
        cnt_minutes_next = cnt_minutes_reg;
        cnt_seconds_next = cnt_seconds_reg;
        cnt_running_next = cnt_running_reg;
        finished_next    = 1'b0;

        unique case (in_mode_reg)
            MODE_TICK: begin
                // Calendar ripple from seconds up to years.
                if (!in_beat_reg.hold_calendar) begin
                    if (cal_second_reg != MIN_SEC_MAX) begin
                        cal_second_next = cal_second_reg + 6'd1;
                    end else begin
                        cal_second_next = 6'd0;
                        if (cal_minute_reg != MIN_SEC_MAX) begin
                            cal_minute_next = cal_minute_reg + 6'd1;
                        end else begin
                            cal_minute_next = 6'd0;
                            if (cal_hour_reg < HOUR_MAX) begin
                                cal_hour_next = cal_hour_reg + 5'd1;
                            end else begin
                                cal_hour_next = 5'd0;
                                if (cal_day_reg < md) begin
                                    cal_day_next = cal_day_reg + 5'd1;
                                end else begin
                                    cal_day_next = 5'd1;
                                    if (cal_month_reg < MONTH_MAX) begin
                                        cal_month_next = cal_month_reg + 4'd1;
                                    end else begin
                                        cal_month_next = 4'd1;
                                        cal_year_next  = (cal_year_reg >= YEAR_MAX) ? 14'd0
                                                       : cal_year_reg + 14'd1;
                                    end
                                end
                            end
                        end
                    end
                end
                // Countdown with borrow when countdown_view is set; a tick that finds zero stops it.
                if (cnt_running_reg && in_beat_reg.countdown_view) begin
                    if (cnt_hours_reg == 7'd0 && cnt_minutes_reg == 6'd0 &&
                        cnt_seconds_reg == 6'd0) begin
                        cnt_running_next = 1'b0;
                        finished_next    = 1'b1;
                    end else if (cnt_seconds_reg != 6'd0) begin
                        cnt_seconds_next = cnt_seconds_reg - 6'd1;
                    end else begin
                        cnt_seconds_next = MIN_SEC_MAX;
                        if (cnt_minutes_reg != 6'd0) begin
                            cnt_minutes_next = cnt_minutes_reg - 6'd1;
                        end else begin
                            cnt_minutes_next = MIN_SEC_MAX;
                            cnt_hours_next   = cnt_hours_reg - 7'd1;
                        end
                    end
                end
            end
            MODE_LOAD_CAL: begin
                cal_year_next   = ld_year;
                cal_month_next  = ld_month;
                cal_day_next    = (ld_day_raw > md) ? md : ld_day_raw;
                cal_hour_next   = (in_beat_reg.load_hour > {2'd0, HOUR_MAX}) ? HOUR_MAX
                                : in_beat_reg.load_hour[4:0];
                cal_minute_next = (in_beat_reg.load_minute > MIN_SEC_MAX) ? MIN_SEC_MAX
                                : in_beat_reg.load_minute;
                cal_second_next = (in_beat_reg.load_second > MIN_SEC_MAX) ? MIN_SEC_MAX
                                : in_beat_reg.load_second;
            end
            MODE_LOAD_CD: begin
                cnt_hours_next   = (in_beat_reg.load_hour > CD_HOUR_MAX) ? CD_HOUR_MAX
                                 : in_beat_reg.load_hour;
                cnt_minutes_next = (in_beat_reg.load_minute > MIN_SEC_MAX) ? MIN_SEC_MAX
                                 : in_beat_reg.load_minute;
                cnt_seconds_next = (in_beat_reg.load_second > MIN_SEC_MAX) ? MIN_SEC_MAX
                                 : in_beat_reg.load_second;
                cnt_running_next = 1'b1;
            end
            MODE_STOP_CD: begin
                cnt_running_next = 1'b0;
            end
            default: begin
                cnt_running_next = cnt_running_reg;
            end
        endcase
    end

    // Result beat shows the state after the update.
    always_comb begin
        out_beat_next            = '0;
        out_beat_next.year       = cal_year_next;
        out_beat_next.month      = cal_month_next;
        out_beat_next.day        = cal_day_next;
        out_beat_next.hour       = cal_hour_next;
        out_beat_next.minute     = cal_minute_next;
        out_beat_next.second     = cal_second_next;
        out_beat_next.cd_hours   = cnt_hours_next;
        out_beat_next.cd_minutes = cnt_minutes_next;
        out_beat_next.cd_seconds = cnt_seconds_next;
        out_beat_next.running    = cnt_running_next;
        out_beat_next.finished   = finished_next;
    end

    // State and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_year_reg    <= YEAR_RESET;
            cal_month_reg   <= 4'd1;
            cal_day_reg     <= 5'd1;
            cal_hour_reg    <= 5'd0;
            cal_minute_reg  <= 6'd0;
            cal_second_reg  <= 6'd0;
            cnt_hours_reg   <= 7'd0;
            cnt_minutes_reg <= 6'd0;
            cnt_seconds_reg <= 6'd0;
            cnt_running_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (advance) begin
                cal_year_reg    <= cal_year_next;
                cal_month_reg   <= cal_month_next;
                cal_day_reg     <= cal_day_next;
                cal_hour_reg    <= cal_hour_next;
                cal_minute_reg  <= cal_minute_next;
                cal_second_reg  <= cal_second_next;
                cnt_hours_reg   <= cnt_hours_next;
                cnt_minutes_reg <= cnt_minutes_next;
                cnt_seconds_reg <= cnt_seconds_next;
                cnt_running_reg <= cnt_running_next;
                m_tvalid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg    <= 1'b0;
            end
        end
        if (advance) begin
            out_beat_reg <= out_beat_next;
        end
    end

    // A finished beat always reports the countdown as stopped.
    a_finished_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_beat_reg.finished |-> !out_beat_reg.running)
        else $error("finished reported with countdown still running");

    // The countdown only starts on a start-countdown beat.
    a_start_by_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(cnt_running_reg) |-> $past(advance) && ($past(in_mode_reg) == MODE_LOAD_CD))
        else $error("countdown started without a load");

    // Time of day stays in range.
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cal_second_reg <= MIN_SEC_MAX && cal_minute_reg <= MIN_SEC_MAX &&
        cal_hour_reg <= HOUR_MAX)
        else $error("calendar time out of range");

    // The day never passes the length of its month, and the month stays in 1 to 12.
    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cal_day_reg != 5'd0 && cal_day_reg <= month_days(cal_year_reg, cal_month_reg) &&
        cal_month_reg != 4'd0 && cal_month_reg <= MONTH_MAX)
        else $error("calendar date out of range");

endmodule

>>> test/tb_top.sv
// Self-checking testbench for clock_calendar_countdown_top: calendar rollovers, leap years,
// clamped loads and countdown finish, predicted per beat and checked field by field.
// Depends on ccc_pkg for the command codes, the beat layouts and the range limits.
module tb_top;
    import ccc_pkg::*;

    localparam int RANDOM_CMDS      = 1100;
    localparam int LONG_HOLD_AT     = 300;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES     = 8;
    localparam int RUN_LIMIT        = 4000000;

    // One command waiting to be driven.
    typedef struct {
        mode_t    mode;
        in_beat_t beat;
        bit       drain;
        bit       burst;
    } cmd_item_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [MODE_W-1:0]      s_tuser = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;

    cmd_item_t cmd_queue[$];
    out_beat_t clock_readings[$];

    int  offered_cnt = 0;
    int  acc_cnt = 0;
    int  res_cnt = 0;
    int  mismatches = 0;
    int  gap_left = 0;
    int  seen_res = 0;
    int  ready_wait = 0;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    bit  calm = 1'b0;

    // Predicted calendar and countdown, starting from the reset values.
    logic [13:0] cal_year  = YEAR_RESET;
    logic [3:0]  cal_month = 4'd1;
    logic [4:0]  cal_day   = 5'd1;
    logic [4:0]  cal_hour  = '0;
    logic [5:0]  cal_min   = '0;
    logic [5:0]  cal_sec   = '0;
    logic [6:0]  cd_hour   = '0;
    logic [5:0]  cd_min    = '0;
    logic [5:0]  cd_sec    = '0;
    logic        cd_run    = 1'b0;

    clock_calendar_countdown_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // Clock with a 20 unit period.
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Gregorian month length.
    function automatic logic [4:0] days_of(input logic [13:0] y, input logic [3:0] m);
        bit leap;
        leap = ((y % 14'd4) == 14'd0 && (y % 14'd100) != 14'd0) || (y % 14'd400) == 14'd0;
        case (m)
            4'd2: begin
                return leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                return 5'd30;
            end
            default: begin
                return 5'd31;
            end
        endcase
    endfunction

    // Applies one command to the predicted state and returns the reading it shows.
    function automatic out_beat_t step_clock(input mode_t md, input in_beat_t b);
        out_beat_t   r;
        logic [13:0] y;
        logic [3:0]  mo;
        logic [4:0]  d;
        logic [4:0]  mdays;
        bit          carry;
        bit          fin;
        fin = 1'b0;
        case (md)
            MODE_TICK: begin
                // Ripple the one-second carry up through the calendar.
                if (!b.hold_calendar) begin
                    carry = 1'b1;
                    if (cal_sec == MIN_SEC_MAX) cal_sec = '0;
                    else begin
                        cal_sec = cal_sec + 6'd1;
                        carry = 1'b0;
                    end
                    if (carry) begin
                        if (cal_min == MIN_SEC_MAX) cal_min = '0;
                        else begin
                            cal_min = cal_min + 6'd1;
                            carry = 1'b0;
                        end
                    end
                    if (carry) begin
                        if (cal_hour == HOUR_MAX) cal_hour = '0;
                        else begin
                            cal_hour = cal_hour + 5'd1;
                            carry = 1'b0;
                        end
                    end
                    if (carry) begin
                        if (cal_day >= days_of(cal_year, cal_month)) cal_day = 5'd1;
                        else begin
                            cal_day = cal_day + 5'd1;
                            carry = 1'b0;
                        end
                    end
                    if (carry) begin
                        if (cal_month >= MONTH_MAX) cal_month = 4'd1;
                        else begin
                            cal_month = cal_month + 4'd1;
                            carry = 1'b0;
                        end
                    end
                    if (carry) begin
                        cal_year = (cal_year >= YEAR_MAX) ? '0 : cal_year + 14'd1;
                    end
                end
                // A running countdown in view borrows down, or stops once it sits at zero.
                if (cd_run && b.countdown_view) begin
                    if (cd_hour == '0 && cd_min == '0 && cd_sec == '0) begin
                        cd_run = 1'b0;
                        fin = 1'b1;
                    end else if (cd_sec != '0) begin
                        cd_sec = cd_sec - 6'd1;
                    end else begin
                        cd_sec = MIN_SEC_MAX;
                        if (cd_min != '0) cd_min = cd_min - 6'd1;
                        else begin
                            cd_min = MIN_SEC_MAX;
                            cd_hour = cd_hour - 7'd1;
                        end
                    end
                end
            end
            MODE_LOAD_CAL: begin
                // Every load value is clamped; the day against the loaded month and year.
                y = (b.load_year > YEAR_MAX) ? YEAR_MAX : b.load_year;
                mo = (b.load_month > MONTH_MAX) ? MONTH_MAX : b.load_month;
                if (mo == '0) mo = 4'd1;
                mdays = days_of(y, mo);
                d = b.load_day;
                if (d == '0) d = 5'd1;
                if (d > mdays) d = mdays;
                cal_year = y;
                cal_month = mo;
                cal_day = d;
                cal_hour = (b.load_hour > {2'b00, HOUR_MAX}) ? HOUR_MAX : b.load_hour[4:0];
                cal_min = (b.load_minute > MIN_SEC_MAX) ? MIN_SEC_MAX : b.load_minute;
                cal_sec = (b.load_second > MIN_SEC_MAX) ? MIN_SEC_MAX : b.load_second;
            end
            MODE_LOAD_CD: begin
                cd_hour = (b.load_hour > CD_HOUR_MAX) ? CD_HOUR_MAX : b.load_hour;
                cd_min = (b.load_minute > MIN_SEC_MAX) ? MIN_SEC_MAX : b.load_minute;
                cd_sec = (b.load_second > MIN_SEC_MAX) ? MIN_SEC_MAX : b.load_second;
                cd_run = 1'b1;
            end
            default: begin
                cd_run = 1'b0;
            end
        endcase
        r = '0;
        r.year = cal_year;
        r.month = cal_month;
        r.day = cal_day;
        r.hour = cal_hour;
        r.minute = cal_min;
        r.second = cal_sec;
        r.cd_hours = cd_hour;
        r.cd_minutes = cd_min;
        r.cd_seconds = cd_sec;
        r.running = cd_run;
        r.finished = fin;
        return r;
    endfunction

    // Counts a mismatch and prints one line for it.
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("reading %0d: %s", res_cnt, msg);
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", what, got, want));
    endtask

    task automatic add_cmd(input mode_t md, input bit hold, input bit view, input int y,
                           input int mo, input int d, input int h, input int mi, input int s,
                           input bit drain, input bit burst);
        cmd_item_t c;
        c.mode = md;
        c.beat = '0;
        c.beat.hold_calendar = hold;
        c.beat.countdown_view = view;
        c.beat.load_year = 14'(y);
        c.beat.load_month = 4'(mo);
        c.beat.load_day = 5'(d);
        c.beat.load_hour = 7'(h);
        c.beat.load_minute = 6'(mi);
        c.beat.load_second = 6'(s);
        c.drain = drain;
        c.burst = burst;
        cmd_queue.push_back(c);
    endtask

    // Driver: offers one command beat at a time, with a drawn gap after each outside bursts.
    always @(negedge aclk) begin
        cmd_item_t c;
        logic      nxt_valid;
        nxt_valid = 1'b0;
        if (aresetn) begin
            if (s_tvalid && acc_cnt != offered_cnt) begin
                nxt_valid = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_queue.size() != 0) begin
                // A drain marker holds the command back until every reading is in.
                if (!cmd_queue[0].drain || clock_readings.size() == 0) begin
                    c = cmd_queue.pop_front();
                    s_tdata <= c.beat;
                    s_tuser <= c.mode;
                    calm <= c.burst;
                    offered_cnt++;
                    gap_left = c.burst ? 0 : $urandom_range(0, 7);
                    nxt_valid = 1'b1;
                end
            end
        end
        s_tvalid <= nxt_valid;
    end

    // Receiver: a drawn wait before each reading outside bursts, plus one long hold-off that backs up the input.
    always @(negedge aclk) begin
        if (res_cnt != seen_res) begin
            seen_res = res_cnt;
            ready_wait = calm ? 0 : $urandom_range(0, 7);
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && acc_cnt >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (ready_wait > 0) begin
            ready_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predicts each accepted command and checks each accepted reading.
    always @(posedge aclk) begin
        out_beat_t got;
        out_beat_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                clock_readings.push_back(step_clock(mode_t'(s_tuser), in_beat_t'(s_tdata)));
                acc_cnt++;
            end
            if (m_tvalid && m_tready) begin
                got = out_beat_t'(m_tdata);
                res_cnt++;
                if (clock_readings.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat %h", m_tdata));
                end else begin
                    want = clock_readings.pop_front();
                    check_field("year", int'(got.year), int'(want.year));
                    check_field("month", int'(got.month), int'(want.month));
                    check_field("day", int'(got.day), int'(want.day));
                    check_field("hour", int'(got.hour), int'(want.hour));
                    check_field("minute", int'(got.minute), int'(want.minute));
                    check_field("second", int'(got.second), int'(want.second));
                    check_field("cd_hours", int'(got.cd_hours), int'(want.cd_hours));
                    check_field("cd_minutes", int'(got.cd_minutes), int'(want.cd_minutes));
                    check_field("cd_seconds", int'(got.cd_seconds), int'(want.cd_seconds));
                    check_field("running", int'(got.running), int'(want.running));
                    check_field("finished", int'(got.finished), int'(want.finished));
                    check_field("padding", int'(got.pad), int'(want.pad));
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int r;
        int y;
        int mo;
        int d;
        int h;
        int mi;
        int s;
        bit burst;
        bit drain;
        mode_t md;

        // Directed: rollovers, leap rules, clamping and the countdown corner cases.
        add_cmd(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_LOAD_CAL, 1, 1, 9999, 12, 31, 23, 59, 59, 0, 0);
        add_cmd(MODE_TICK, 0, 1, 16383, 15, 31, 127, 63, 63, 0, 0);
        add_cmd(MODE_LOAD_CAL, 0, 0, 0, 2, 28, 23, 59, 59, 0, 0);
        add_cmd(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_LOAD_CAL, 0, 0, 1900, 2, 29, 23, 59, 59, 0, 0);
        add_cmd(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_LOAD_CAL, 0, 0, 2000, 2, 29, 23, 59, 59, 0, 0);
        add_cmd(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_LOAD_CAL, 0, 0, 2024, 4, 31, 23, 59, 59, 0, 0);
        add_cmd(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_LOAD_CAL, 0, 0, 16383, 15, 31, 127, 63, 63, 0, 0);
        add_cmd(MODE_LOAD_CAL, 0, 0, 2023, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_TICK, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_LOAD_CD, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_TICK, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_LOAD_CD, 0, 0, 16383, 15, 31, 127, 63, 63, 0, 0);
        add_cmd(MODE_TICK, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_LOAD_CD, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0);
        add_cmd(MODE_TICK, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_LOAD_CD, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
        add_cmd(MODE_TICK, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_TICK, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_LOAD_CD, 0, 0, 0, 0, 0, 0, 0, 5, 0, 0);
        add_cmd(MODE_STOP_CD, 1, 1, 16383, 15, 31, 127, 63, 63, 0, 0);
        add_cmd(MODE_TICK, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);

        // Random: mostly ticks, with loads placed near rollovers and short countdowns.
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            burst = (i >= 260 && i < 520) || (i >= 900 && i < 1000);
            drain = (i == 0) || (i == 650);
            y = $urandom_range(0, 16383);
            mo = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
            h = $urandom_range(0, 127);
            mi = $urandom_range(0, 63);
            s = $urandom_range(0, 63);
            r = $urandom_range(0, 99);
            if (r < 68) begin
                md = MODE_TICK;
            end else if (r < 80) begin
                md = MODE_LOAD_CAL;
                case ($urandom_range(0, 3))
                    0: begin
                        // Raw field bits, clamping included.
                    end
                    1: begin
                        case ($urandom_range(0, 6))
                            0: y = 0;
                            1: y = 1900;
                            2: y = 2000;
                            3: y = 2023;
                            4: y = 2024;
                            5: y = 2100;
                            default: y = 9999;
                        endcase
                        mo = $urandom_range(1, 12);
                        d = $urandom_range(28, 31);
                        h = 23;
                        mi = 59;
                        s = $urandom_range(50, 59);
                    end
                    2: begin
                        y = $urandom_range(0, 9999);
                        mo = $urandom_range(1, 12);
                        d = $urandom_range(1, 31);
                        h = $urandom_range(0, 23);
                        mi = $urandom_range(0, 59);
                        s = $urandom_range(0, 59);
                    end
                    default: begin
                        y = $urandom_range(0, 9999);
                        mo = $urandom_range(1, 12);
                        h = $urandom_range(22, 23);
                        mi = 59;
                        s = $urandom_range(45, 59);
                    end
                endcase
            end else if (r < 93) begin
                md = MODE_LOAD_CD;
                case ($urandom_range(0, 3))
                    0: begin
                        // Raw field bits, clamping included.
                    end
                    1: begin
                        h = $urandom_range(0, 1);
                        mi = $urandom_range(0, 1);
                        s = $urandom_range(0, 2);
                    end
                    default: begin
                        h = 0;
                        mi = 0;
                        s = $urandom_range(0, 6);
                    end
                endcase
            end else begin
                md = MODE_STOP_CD;
            end
            add_cmd(md, ($urandom_range(0, 9) == 0), ($urandom_range(0, 5) != 0),
                    y, mo, d, h, mi, s, drain, burst);
        end

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        while (cmd_queue.size() != 0 || acc_cnt != offered_cnt || clock_readings.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
design/ccc_pkg.sv
design/clock_calendar_countdown_top.sv
test/tb_top.sv
